>>> hw/rtl/ffha_pkg.sv
// shared types, constants and codes for the first-fit heap allocator
// no dependencies; imported by every rtl file of the block except ffha_ram
package ffha_pkg;

    localparam int GRANULE_BYTES    = 16;
    localparam int GRAN_SHIFT       = $clog2(GRANULE_BYTES);
    localparam int HEAP_GRANULES_DEF = 1024;
    localparam int OFF_W            = 15;
    localparam int REQ_W            = 2;

    localparam logic [REQ_W-1:0] REQ_ALLOC  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RESIZE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [OFF_W-1:0] block_offset;
        logic [OFF_W-1:0] size_bytes;
    } in_beat_t;

    typedef struct packed {
        logic             granted;
        logic [OFF_W-1:0] payload_offset;
    } out_beat_t;

    // operand sources for addresses, write data and register loads
    typedef enum logic [3:0] {
        V_ZERO,
        V_ONE,
        V_B,
        V_T,
        V_N,
        V_P,
        V_UX,
        V_HEAD,
        V_DEC,
        V_QNEXT,
        V_QPREV,
        V_QFNEXT,
        V_QFPREV
    } val_sel_e;

    typedef struct packed {
        logic nxt;
        logic prv;
        logic fnx;
        logic fpv;
        logic used;
    } ram_sel_t;

    typedef enum logic [5:0] {
        S_INIT, S_IDLE, S_DISPATCH,
        S_A_TEST, S_A_CHK, S_A_TAKE,
        S_SP1, S_SP2, S_SP3, S_SP4, S_SP5, S_SP6, S_SP7, S_SP8, S_SP9,
        S_U_RD, S_U_F1, S_U_F2, S_U_B1, S_U_B2,
        S_G_RD, S_G_CHK,
        S_SH1, S_SH2, S_SH3, S_SH4,
        S_PU1, S_PU2, S_PU3, S_PU4,
        S_MN_TEST, S_MN_CHK, S_MP_TEST, S_MP_CHK,
        S_GR_RD, S_GR_CHK,
        S_DONE_OK, S_DONE_FAIL
    } state_e;

    typedef struct packed {
        logic     in_ld;
        logic     rd_en;
        val_sel_e rd_sel;
        ram_sel_t wr;
        val_sel_e wr_addr;
        val_sel_e wr_data;
        logic     used_val;
        logic     head_ld;
        val_sel_e head_src;
        logic     b_ld;
        val_sel_e b_src;
        logic     t_ld;
        logic     n_ld;
        logic     p_ld;
        logic     u_ld;
        logic     ux_ld;
        val_sel_e ux_src;
        logic     k_clr;
        logic     k_inc;
        logic     out_ld;
        logic     out_grant;
    } ffha_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic dec_ok;
        logic b_zero;
        logic k_done;
        logic q_used;
        logic q_next_zero;
        logic q_prev_zero;
        logic q_fnext_zero;
        logic q_fprev_zero;
        logic n_zero;
        logic p_zero;
        logic head_zero;
        logic u_ge_need;
        logic u_gt_need;
        logic need_gt_comb;
        logic need_lt_comb;
        logic out_free;
    } ffha_sts_t;

endpackage

>>> hw/rtl/ffha_ram.sv
// generic single-write, single-read ram with registered read data
// depends on nothing
module ffha_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/ffha_datapath.sv
// datapath: link stores, working registers, free list head and result register
// depends on ffha_pkg and ffha_ram
module ffha_datapath #(
    parameter int HEAP_GRANULES = ffha_pkg::HEAP_GRANULES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ffha_pkg::in_beat_t  in_data,
    input  ffha_pkg::ffha_cmd_t cmd,
    output ffha_pkg::ffha_sts_t sts,
    output logic                out_valid,
    input  logic                out_stall,
    output ffha_pkg::out_beat_t out_data
);
    import ffha_pkg::*;

    localparam int GW = $clog2(HEAP_GRANULES);
    localparam int SW = (GW + 2 > 13) ? GW + 2 : 13;
    localparam int QW = OFF_W - GRAN_SHIFT;
    localparam logic [SW-1:0] HG = SW'(HEAP_GRANULES);

    logic [REQ_W-1:0] req_reg;
    logic [OFF_W-1:0] off_reg;
    logic [SW-1:0]    need_reg;
    logic [GW-1:0]    b_reg, t_reg, n_reg, p_reg, ux_reg, rd_addr_reg;
    logic [GW-1:0]    head_reg;
    logic [SW-1:0]    u_reg, k_reg;
    out_beat_t        out_reg;
    logic             out_valid_reg;

    logic [GW-1:0] q_next, q_prev, q_fnext, q_fprev;
    logic          q_used;

    logic [GW-1:0] rd_addr, wr_addr, wr_data, head_val, b_val, ux_val;
    logic [OFF_W:0] need_sum;
    logic [QW-1:0]  q_gran, dec_g;
    logic [GW-1:0]  dec_val;
    logic [SW-1:0]  end_v, base_v, u_q, t_sum, comb, pay_gran;
    logic [OFF_W-1:0] pay;

    function automatic logic [GW-1:0] pick(
        input val_sel_e s,
        input logic [GW-1:0] b, t, n, p, ux, hd, dec, qn, qp, qfn, qfp
    );
        logic [GW-1:0] v;
        begin
            unique case (s)
                V_ZERO:   v = '0;
                V_ONE:    v = GW'(1);
                V_B:      v = b;
                V_T:      v = t;
                V_N:      v = n;
                V_P:      v = p;
                V_UX:     v = ux;
                V_HEAD:   v = hd;
                V_DEC:    v = dec;
                V_QNEXT:  v = qn;
                V_QPREV:  v = qp;
                V_QFNEXT: v = qfn;
                V_QFPREV: v = qfp;
                default:  v = '0;
            endcase
            return v;
        end
    endfunction

    // request decode
    assign need_sum = (OFF_W+1)'(in_data.size_bytes) + (OFF_W+1)'(GRANULE_BYTES - 1);
    assign q_gran   = off_reg[OFF_W-1:GRAN_SHIFT];
    assign dec_g    = q_gran - QW'(1);
    assign dec_val  = GW'(dec_g);

    always_comb
    begin
        rd_addr  = pick(cmd.rd_sel, b_reg, t_reg, n_reg, p_reg, ux_reg, head_reg,
                        dec_val, q_next, q_prev, q_fnext, q_fprev);
        wr_addr  = pick(cmd.wr_addr, b_reg, t_reg, n_reg, p_reg, ux_reg, head_reg,
                        dec_val, q_next, q_prev, q_fnext, q_fprev);
        wr_data  = pick(cmd.wr_data, b_reg, t_reg, n_reg, p_reg, ux_reg, head_reg,
                        dec_val, q_next, q_prev, q_fnext, q_fprev);
        head_val = pick(cmd.head_src, b_reg, t_reg, n_reg, p_reg, ux_reg, head_reg,
                        dec_val, q_next, q_prev, q_fnext, q_fprev);
        b_val    = pick(cmd.b_src, b_reg, t_reg, n_reg, p_reg, ux_reg, head_reg,
                        dec_val, q_next, q_prev, q_fnext, q_fprev);
        ux_val   = pick(cmd.ux_src, b_reg, t_reg, n_reg, p_reg, ux_reg, head_reg,
                        dec_val, q_next, q_prev, q_fnext, q_fprev);
    end

    // usable granules of the block last read
    assign end_v    = (q_next == '0) ? HG : SW'(q_next);
    assign base_v   = SW'(rd_addr_reg);
    assign u_q      = (end_v > base_v) ? end_v - base_v - SW'(1) : '0;
    assign comb     = u_reg + u_q + SW'(1);
    assign t_sum    = SW'(b_reg) + need_reg + SW'(1);
    assign pay_gran = SW'(b_reg) + SW'(1);
    assign pay      = {pay_gran[QW-1:0], GRAN_SHIFT'(0)};

    ffha_ram #(.WIDTH(GW), .DEPTH(HEAP_GRANULES)) u_next_ram (
        .clk(clk), .we(cmd.wr.nxt), .waddr(wr_addr), .wdata(wr_data),
        .re(cmd.rd_en), .raddr(rd_addr), .rdata(q_next)
    );
    ffha_ram #(.WIDTH(GW), .DEPTH(HEAP_GRANULES)) u_prev_ram (
        .clk(clk), .we(cmd.wr.prv), .waddr(wr_addr), .wdata(wr_data),
        .re(cmd.rd_en), .raddr(rd_addr), .rdata(q_prev)
    );
    ffha_ram #(.WIDTH(GW), .DEPTH(HEAP_GRANULES)) u_fnext_ram (
        .clk(clk), .we(cmd.wr.fnx), .waddr(wr_addr), .wdata(wr_data),
        .re(cmd.rd_en), .raddr(rd_addr), .rdata(q_fnext)
    );
    ffha_ram #(.WIDTH(GW), .DEPTH(HEAP_GRANULES)) u_fprev_ram (
        .clk(clk), .we(cmd.wr.fpv), .waddr(wr_addr), .wdata(wr_data),
        .re(cmd.rd_en), .raddr(rd_addr), .rdata(q_fprev)
    );
    ffha_ram #(.WIDTH(1), .DEPTH(HEAP_GRANULES)) u_used_ram (
        .clk(clk), .we(cmd.wr.used), .waddr(wr_addr), .wdata(cmd.used_val),
        .re(cmd.rd_en), .raddr(rd_addr), .rdata(q_used)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= GW'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.head_ld)
            begin
                head_reg <= head_val;
            end
            if (cmd.out_ld)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.in_ld)
        begin
            req_reg  <= in_data.req_type;
            off_reg  <= in_data.block_offset;
            need_reg <= SW'(need_sum >> GRAN_SHIFT);
        end
        if (cmd.rd_en)
        begin
            rd_addr_reg <= rd_addr;
        end
        if (cmd.b_ld)
        begin
            b_reg <= b_val;
        end
        if (cmd.t_ld)
        begin
            t_reg <= t_sum[GW-1:0];
        end
        if (cmd.n_ld)
        begin
            n_reg <= q_next;
        end
        if (cmd.p_ld)
        begin
            p_reg <= q_prev;
        end
        if (cmd.u_ld)
        begin
            u_reg <= u_q;
        end
        if (cmd.ux_ld)
        begin
            ux_reg <= ux_val;
        end
        if (cmd.k_clr)
        begin
            k_reg <= '0;
        end
        else if (cmd.k_inc)
        begin
            k_reg <= k_reg + SW'(1);
        end
        if (cmd.out_ld)
        begin
            out_reg.granted <= cmd.out_grant;
            if (!cmd.out_grant)
            begin
                out_reg.payload_offset <= '0;
            end
            else if (req_reg == REQ_ALLOC)
            begin
                out_reg.payload_offset <= pay;
            end
            else
            begin
                out_reg.payload_offset <= off_reg;
            end
        end
    end

    always_comb
    begin
        sts.req          = req_reg;
        sts.dec_ok       = (off_reg[GRAN_SHIFT-1:0] == '0) && (q_gran != '0)
                           && (dec_g != '0) && (SW'(dec_g) < HG);
        sts.b_zero       = (b_reg == '0);
        sts.k_done       = (k_reg == HG);
        sts.q_used       = q_used;
        sts.q_next_zero  = (q_next == '0);
        sts.q_prev_zero  = (q_prev == '0);
        sts.q_fnext_zero = (q_fnext == '0);
        sts.q_fprev_zero = (q_fprev == '0);
        sts.n_zero       = (n_reg == '0);
        sts.p_zero       = (p_reg == '0);
        sts.head_zero    = (head_reg == '0);
        sts.u_ge_need    = (u_q >= need_reg);
        sts.u_gt_need    = (u_q > need_reg);
        sts.need_gt_comb = (need_reg > comb);
        sts.need_lt_comb = (need_reg < comb);
        sts.out_free     = !out_valid_reg || !out_stall;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

>>> hw/rtl/ffha_ctrl.sv
// controller: sequences the free list walk, splits, pushes and merges
// depends on ffha_pkg
module ffha_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ffha_pkg::ffha_sts_t sts,
    output ffha_pkg::ffha_cmd_t cmd
);
    import ffha_pkg::*;

    state_e state_reg, state_next;
    logic   blk_reg, blk_next;
    logic   ret_mp_reg, ret_mp_next;
    state_e ret_state;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            blk_reg    <= 1'b0;
            ret_mp_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            blk_reg    <= blk_next;
            ret_mp_reg <= ret_mp_next;
        end
    end

    assign ret_state = ret_mp_reg ? S_MP_TEST : S_DONE_OK;
    assign in_stall  = (state_reg != S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        blk_next    = blk_reg;
        ret_mp_next = ret_mp_reg;
        cmd         = '0;

        unique case (state_reg)
            S_INIT:
            begin
                // entry 1 holds the single free block spanning the arena
                cmd.wr      = '{nxt: 1'b1, prv: 1'b1, fnx: 1'b1, fpv: 1'b1, used: 1'b1};
                cmd.wr_addr = V_ONE;
                cmd.wr_data = V_ZERO;
                state_next  = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.in_ld  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (sts.req) inside
                    REQ_ALLOC:
                    begin
                        cmd.b_ld   = 1'b1;
                        cmd.b_src  = V_HEAD;
                        cmd.k_clr  = 1'b1;
                        state_next = S_A_TEST;
                    end
                    REQ_FREE, REQ_RESIZE:
                    begin
                        if (sts.dec_ok)
                        begin
                            cmd.b_ld   = 1'b1;
                            cmd.b_src  = V_DEC;
                            state_next = S_G_RD;
                        end
                        else
                        begin
                            state_next = S_DONE_FAIL;
                        end
                    end
                    default: state_next = S_DONE_FAIL;
                endcase
            end
            S_A_TEST:
            begin
                if (sts.b_zero || sts.k_done)
                begin
                    state_next = S_DONE_FAIL;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = V_B;
                    state_next = S_A_CHK;
                end
            end
            S_A_CHK:
            begin
                if (sts.u_ge_need)
                begin
                    cmd.t_ld   = 1'b1;
                    cmd.ux_ld  = 1'b1;
                    cmd.ux_src = V_B;
                    state_next = S_A_TAKE;
                end
                else
                begin
                    cmd.b_ld   = 1'b1;
                    cmd.b_src  = V_QFNEXT;
                    cmd.k_inc  = 1'b1;
                    state_next = S_A_TEST;
                end
            end
            S_A_TAKE:
            begin
                cmd.wr.used  = 1'b1;
                cmd.wr_addr  = V_B;
                cmd.used_val = 1'b1;
                blk_next     = 1'b0;
                ret_mp_next  = 1'b0;
                state_next   = sts.u_gt_need ? S_SP1 : S_U_RD;
            end
            // split the tail of block ux off as a free block t after it
            S_SP1:
            begin
                cmd.wr.prv  = 1'b1;
                cmd.wr_addr = V_T;
                cmd.wr_data = V_UX;
                state_next  = S_SP2;
            end
            S_SP2:
            begin
                cmd.wr.nxt  = 1'b1;
                cmd.wr_addr = V_T;
                cmd.wr_data = V_QNEXT;
                state_next  = S_SP3;
            end
            S_SP3:
            begin
                cmd.wr.nxt  = 1'b1;
                cmd.wr_addr = V_UX;
                cmd.wr_data = V_T;
                state_next  = S_SP4;
            end
            S_SP4:
            begin
                cmd.wr.prv  = !sts.q_next_zero;
                cmd.wr_addr = V_QNEXT;
                cmd.wr_data = V_T;
                state_next  = S_SP5;
            end
            S_SP5:
            begin
                cmd.wr.fpv  = 1'b1;
                cmd.wr_addr = V_T;
                cmd.wr_data = V_UX;
                state_next  = S_SP6;
            end
            S_SP6:
            begin
                cmd.wr.fnx  = 1'b1;
                cmd.wr_addr = V_T;
                cmd.wr_data = V_QFNEXT;
                state_next  = S_SP7;
            end
            S_SP7:
            begin
                cmd.wr.fnx  = 1'b1;
                cmd.wr_addr = V_UX;
                cmd.wr_data = V_T;
                state_next  = S_SP8;
            end
            S_SP8:
            begin
                cmd.wr.fpv  = !sts.q_fnext_zero;
                cmd.wr_addr = V_QFNEXT;
                cmd.wr_data = V_T;
                state_next  = S_SP9;
            end
            S_SP9:
            begin
                cmd.wr.used  = 1'b1;
                cmd.wr_addr  = V_T;
                cmd.used_val = 1'b0;
                state_next   = S_U_RD;
            end
            // unlink ux from the free list, and from the block list if blk
            S_U_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = V_UX;
                state_next = S_U_F1;
            end
            S_U_F1:
            begin
                if (sts.q_fprev_zero)
                begin
                    cmd.head_ld  = 1'b1;
                    cmd.head_src = V_QFNEXT;
                end
                else
                begin
                    cmd.wr.fnx  = 1'b1;
                    cmd.wr_addr = V_QFPREV;
                    cmd.wr_data = V_QFNEXT;
                end
                state_next = S_U_F2;
            end
            S_U_F2:
            begin
                cmd.wr.fpv  = !sts.q_fnext_zero;
                cmd.wr_addr = V_QFNEXT;
                cmd.wr_data = V_QFPREV;
                state_next  = blk_reg ? S_U_B1 : ret_state;
            end
            S_U_B1:
            begin
                cmd.wr.nxt  = !sts.q_prev_zero;
                cmd.wr_addr = V_QPREV;
                cmd.wr_data = V_QNEXT;
                state_next  = S_U_B2;
            end
            S_U_B2:
            begin
                cmd.wr.prv  = !sts.q_next_zero;
                cmd.wr_addr = V_QNEXT;
                cmd.wr_data = V_QPREV;
                state_next  = ret_state;
            end
            S_G_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = V_B;
                state_next = S_G_CHK;
            end
            S_G_CHK:
            begin
                cmd.t_ld = 1'b1;
                cmd.n_ld = 1'b1;
                cmd.p_ld = 1'b1;
                cmd.u_ld = 1'b1;
                if (!sts.q_used)
                begin
                    state_next = S_DONE_FAIL;
                end
                else if (sts.req == REQ_FREE)
                begin
                    cmd.ux_ld   = 1'b1;
                    cmd.ux_src  = V_B;
                    ret_mp_next = 1'b1;
                    state_next  = S_PU1;
                end
                else if (sts.u_gt_need)
                begin
                    ret_mp_next = 1'b0;
                    state_next  = S_SH1;
                end
                else if (!sts.u_ge_need)
                begin
                    state_next = sts.q_next_zero ? S_DONE_FAIL : S_GR_RD;
                end
                else
                begin
                    state_next = S_DONE_OK;
                end
            end
            // shrink: cut the tail t off block b
            S_SH1:
            begin
                cmd.wr.prv  = 1'b1;
                cmd.wr_addr = V_T;
                cmd.wr_data = V_B;
                state_next  = S_SH2;
            end
            S_SH2:
            begin
                cmd.wr.nxt  = 1'b1;
                cmd.wr_addr = V_T;
                cmd.wr_data = V_N;
                state_next  = S_SH3;
            end
            S_SH3:
            begin
                cmd.wr.nxt  = 1'b1;
                cmd.wr_addr = V_B;
                cmd.wr_data = V_T;
                state_next  = S_SH4;
            end
            S_SH4:
            begin
                cmd.wr.prv  = !sts.n_zero;
                cmd.wr_addr = V_N;
                cmd.wr_data = V_T;
                cmd.ux_ld   = 1'b1;
                cmd.ux_src  = V_T;
                state_next  = S_PU1;
            end
            // push ux at the head of the free list
            S_PU1:
            begin
                cmd.wr.fpv  = 1'b1;
                cmd.wr_addr = V_UX;
                cmd.wr_data = V_ZERO;
                state_next  = S_PU2;
            end
            S_PU2:
            begin
                cmd.wr.fnx  = 1'b1;
                cmd.wr_addr = V_UX;
                cmd.wr_data = V_HEAD;
                state_next  = S_PU3;
            end
            S_PU3:
            begin
                cmd.wr.fpv  = !sts.head_zero;
                cmd.wr_addr = V_HEAD;
                cmd.wr_data = V_UX;
                state_next  = S_PU4;
            end
            S_PU4:
            begin
                cmd.head_ld  = 1'b1;
                cmd.head_src = V_UX;
                cmd.wr.used  = 1'b1;
                cmd.wr_addr  = V_UX;
                cmd.used_val = 1'b0;
                state_next   = S_MN_TEST;
            end
            S_MN_TEST:
            begin
                if (sts.n_zero)
                begin
                    state_next = ret_state;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = V_N;
                    state_next = S_MN_CHK;
                end
            end
            S_MN_CHK:
            begin
                if (!sts.q_used)
                begin
                    cmd.ux_ld  = 1'b1;
                    cmd.ux_src = V_N;
                    blk_next   = 1'b1;
                    state_next = S_U_RD;
                end
                else
                begin
                    state_next = ret_state;
                end
            end
            S_MP_TEST:
            begin
                ret_mp_next = 1'b0;
                if (sts.p_zero)
                begin
                    state_next = S_DONE_OK;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = V_P;
                    state_next = S_MP_CHK;
                end
            end
            S_MP_CHK:
            begin
                if (!sts.q_used)
                begin
                    cmd.ux_ld  = 1'b1;
                    cmd.ux_src = V_B;
                    blk_next   = 1'b1;
                    state_next = S_U_RD;
                end
                else
                begin
                    state_next = S_DONE_OK;
                end
            end
            // grow: absorb the free next block n
            S_GR_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = V_N;
                state_next = S_GR_CHK;
            end
            S_GR_CHK:
            begin
                if (sts.q_used || sts.need_gt_comb)
                begin
                    state_next = S_DONE_FAIL;
                end
                else
                begin
                    cmd.ux_ld   = 1'b1;
                    cmd.ux_src  = V_N;
                    blk_next    = 1'b1;
                    ret_mp_next = 1'b0;
                    state_next  = sts.need_lt_comb ? S_SP1 : S_U_RD;
                end
            end
            S_DONE_OK:
            begin
                if (sts.out_free)
                begin
                    cmd.out_ld    = 1'b1;
                    cmd.out_grant = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_DONE_FAIL:
            begin
                if (sts.out_free)
                begin
                    cmd.out_ld = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

>>> hw/rtl/first_fit_heap_allocator.sv
// first-fit heap allocator: one request beat in, one result beat out
// allocate walks the free list to the first fit and splits off any spare tail; free and
// resize check the block first, and a rejected one fails; one request at a time
// reset: the init state entered as rst_n releases sets up the single free block, then idle
// built from ffha_ctrl and ffha_datapath, types from ffha_pkg
module first_fit_heap_allocator #(
    parameter int HEAP_GRANULES = ffha_pkg::HEAP_GRANULES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ffha_pkg::in_beat_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output ffha_pkg::out_beat_t out_data
);
    import ffha_pkg::*;

    ffha_cmd_t cmd;
    ffha_sts_t sts;

    ffha_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    ffha_datapath #(.HEAP_GRANULES(HEAP_GRANULES)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

>>> hw/rtl/ffha_checker.sv
// port-level checks for the first-fit heap allocator, bound to the top level
// depends on ffha_pkg and first_fit_heap_allocator
module ffha_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input ffha_pkg::in_beat_t  in_data,
    input logic                out_valid,
    input logic                out_stall,
    input ffha_pkg::out_beat_t out_data
);
    import ffha_pkg::*;

    // one request at a time: an accepted beat closes the input
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input open right after accepting a beat");

    // a result only follows a busy period
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without work");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.granted |-> out_data.payload_offset == '0)
        else $error("failed result with nonzero offset");

    a_grant_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.granted |-> out_data.payload_offset != '0)
        else $error("granted result at offset zero");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result beat changed");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (.*);
